/* src/afp_pkg.sv */
// Shared types, constants and helper functions for the manufacturer field parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package afp_pkg;

	// packet and header geometry
	localparam int unsigned MAX_PACKET = 31;
	localparam int unsigned HEADER_MIN = 5;
	localparam int unsigned HDR_BYTES  = 5;
	localparam logic [7:0]  MFG_TYPE   = 8'hFF;
	localparam logic [7:0]  CODE_MASK  = 8'h0F;

	// output queue depth (power of two)
	localparam int unsigned FIFO_DEPTH = 4;

	// word kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT_PKT = 3'd1,
		ST_NO_FIELD  = 3'd2,
		ST_HDR_SHORT = 3'd3,
		ST_COMPANY   = 3'd4,
		ST_MODE      = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		CFG_COMPANY = 3'd0,
		CFG_PAIRING = 3'd1,
		CFG_PAIRED  = 3'd2,
		CFG_LOST    = 3'd3,
		CFG_ENABLE  = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_PAIRING = 2'd0,
		ACT_PAIRED  = 2'd1,
		ACT_LOST    = 2'd2
	} action_t;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_WALK = 5'b00010,
		PH_HDR  = 5'b00100,
		PH_PAY  = 5'b01000,
		PH_DONE = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [15:0] company;
		logic [3:0]  pairing;
		logic [3:0]  paired;
		logic [3:0]  lost;
		logic [2:0]  enable;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [2:0]  status;
		logic [15:0] company;
		logic [7:0]  ver_byte;
		logic [7:0]  flag_bits;
		logic [1:0]  action;
		logic [4:0]  payload_count;
		logic        last;
	} result_t;

	// payload word: only the byte is carried
	function automatic result_t payload_item(input logic [7:0] b);
		result_t r;
		r              = '0;
		r.kind         = KIND_PAYLOAD;
		r.payload_byte = b;
		return r;
	endfunction

	// status word: header fields only on success
	function automatic result_t status_item(
		input status_t     st,
		input logic [15:0] company,
		input logic [7:0]  version,
		input logic [7:0]  flags,
		input logic [1:0]  action,
		input logic [4:0]  count
	);
		result_t r;
		r        = '0;
		r.kind   = KIND_STATUS;
		r.status = st;
		r.last   = 1'b1;
		if (st == ST_OK) begin
			r.company       = company;
			r.ver_byte      = version;
			r.flag_bits     = flags;
			r.action        = action;
			r.payload_count = count;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/afp_if.sv */
// Valid/ready channel interfaces for packet bytes in and parsed words out.
// Depends on afp_pkg for field types.
`default_nettype none

interface afp_in_if import afp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic [4:0] packet_len;

	modport source (output valid, data_byte, first_byte, packet_len, input ready);
	modport sink (input valid, data_byte, first_byte, packet_len, output ready);
endinterface

interface afp_out_if import afp_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [2:0]  status;
	logic [15:0] company;
	logic [7:0]  ver_byte;
	logic [7:0]  flag_bits;
	logic [1:0]  action;
	logic [4:0]  payload_count;
	logic        last;

	modport source (output valid, kind, payload_byte, status, company, ver_byte,
		flag_bits, action, payload_count, last, input ready);
	modport sink (input valid, kind, payload_byte, status, company, ver_byte,
		flag_bits, action, payload_count, last, output ready);
endinterface

`default_nettype wire

/* src/afp_core.sv */
// Per-byte parse state machine: walks AD structures, checks the manufacturer header,
// and emits zero, one or two result words per byte. Depends on afp_pkg.
`default_nettype none

module afp_core import afp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] data_byte,
	input  wire logic       first_byte,
	input  wire logic [4:0] packet_len,
	input  wire cfg_t       cfg,
	output logic [1:0]      res_n,
	output result_t         res0,
	output result_t         res1
);

	localparam logic [5:0] OFF_TYPE    = 6'd1;
	localparam logic [5:0] OFF_CO_LO   = 6'd2;
	localparam logic [5:0] OFF_CO_HI   = 6'd3;
	localparam logic [5:0] OFF_VERSION = 6'd4;
	localparam logic [5:0] OFF_FLAGS   = 6'd5;

	phase_t      phase_q, e_phase, n_phase;
	logic [4:0]  pos_q, e_pos, n_pos;
	logic [4:0]  total_q, e_total, n_total;
	logic [4:0]  nfs_q, e_nfs, n_nfs;
	logic [4:0]  fl_q, e_fl, n_fl;
	logic [15:0] company_q, e_company, n_company;
	logic [7:0]  version_q, e_version, n_version;
	logic [7:0]  flags_q, e_flags, n_flags;
	logic [1:0]  action_q, e_action, n_action;
	logic [4:0]  left_q, e_left, n_left;

	logic [4:0]  len_c;
	logic        short_pkt;
	logic [5:0]  pos6, nfs6;
	logic [8:0]  field_end;
	logic [6:0]  nxt;
	logic [3:0]  code;
	logic [1:0]  sel;
	logic        sel_ok;
	logic [4:0]  hdr_left;
	logic [15:0] company_full;

	// clamp length and check the minimum on a first byte
	assign len_c     = ({3'b0, packet_len} > 8'(MAX_PACKET)) ? 5'(MAX_PACKET) : packet_len;
	assign short_pkt = first_byte && (len_c < 5'd2);

	// offsets of the current byte relative to the field start
	assign pos6         = {1'b0, e_pos};
	assign nfs6         = {1'b0, e_nfs};
	assign field_end    = {4'b0, e_nfs} + {1'b0, data_byte};
	assign nxt          = {2'b0, e_nfs} + {2'b0, e_fl} + 7'd1;
	assign code         = 4'(data_byte & CODE_MASK);
	assign hdr_left     = e_fl - 5'(HDR_BYTES);
	assign company_full = {data_byte, e_company[7:0]};

	// decode message nibble; pairing wins over paired over lost
	always_comb begin
		sel    = ACT_PAIRING;
		sel_ok = 1'b1;
		priority if (code == cfg.pairing) begin
			sel = ACT_PAIRING;
		end else if (code == cfg.paired) begin
			sel = ACT_PAIRED;
		end else if (code == cfg.lost) begin
			sel = ACT_LOST;
		end else begin
			sel_ok = 1'b0;
		end
	end

	// restart the state on a first byte
	always_comb begin
		e_phase   = phase_q;
		e_pos     = pos_q;
		e_total   = total_q;
		e_nfs     = nfs_q;
		e_fl      = fl_q;
		e_company = company_q;
		e_version = version_q;
		e_flags   = flags_q;
		e_action  = action_q;
		e_left    = left_q;
		if (first_byte) begin
			e_phase   = PH_WALK;
			e_pos     = '0;
			e_total   = len_c;
			e_nfs     = '0;
			e_fl      = '0;
			e_company = '0;
			e_version = '0;
			e_flags   = '0;
			e_action  = '0;
			e_left    = '0;
		end
	end

	// parse one byte
	always_comb begin
		n_phase   = e_phase;
		n_pos     = e_pos;
		n_total   = e_total;
		n_nfs     = e_nfs;
		n_fl      = e_fl;
		n_company = e_company;
		n_version = e_version;
		n_flags   = e_flags;
		n_action  = e_action;
		n_left    = e_left;
		res_n     = 2'd0;
		res0      = '0;
		res1      = '0;
		if (short_pkt) begin
			n_phase = PH_DONE;
			res0    = status_item(ST_SHORT_PKT, '0, '0, '0, '0, '0);
			res_n   = 2'd1;
		end else begin
			unique case (e_phase)
				PH_WALK: begin
					if (pos6 == nfs6) begin
						if (data_byte == 8'd0 || field_end >= {4'b0, e_total}) begin
							n_phase = PH_DONE;
							res0    = status_item(ST_NO_FIELD, '0, '0, '0, '0, '0);
							res_n   = 2'd1;
						end else begin
							n_fl = data_byte[4:0];
						end
					end else if (pos6 == nfs6 + OFF_TYPE) begin
						if (data_byte == MFG_TYPE) begin
							if ({3'b0, e_fl} < 8'(HEADER_MIN)) begin
								n_phase = PH_DONE;
								res0    = status_item(ST_HDR_SHORT, '0, '0, '0, '0, '0);
								res_n   = 2'd1;
							end else begin
								n_phase = PH_HDR;
							end
						end else if (nxt + 7'd1 >= {2'b0, e_total}) begin
							n_phase = PH_DONE;
							res0    = status_item(ST_NO_FIELD, '0, '0, '0, '0, '0);
							res_n   = 2'd1;
						end else begin
							n_nfs = nxt[4:0];
						end
					end
				end
				PH_HDR: begin
					priority if (pos6 == nfs6 + OFF_CO_LO) begin
						n_company = {8'd0, data_byte};
					end else if (pos6 == nfs6 + OFF_CO_HI) begin
						n_company = company_full;
						if (company_full != cfg.company) begin
							n_phase = PH_DONE;
							res0    = status_item(ST_COMPANY, '0, '0, '0, '0, '0);
							res_n   = 2'd1;
						end
					end else if (pos6 == nfs6 + OFF_VERSION) begin
						n_version = data_byte;
						if (!sel_ok || !cfg.enable[sel]) begin
							n_phase = PH_DONE;
							res0    = status_item(ST_MODE, '0, '0, '0, '0, '0);
							res_n   = 2'd1;
						end else begin
							n_action = sel;
						end
					end else if (pos6 == nfs6 + OFF_FLAGS) begin
						n_flags = data_byte;
						n_left  = hdr_left;
						if (hdr_left == 5'd0) begin
							n_phase = PH_DONE;
							res0    = status_item(ST_OK, e_company, e_version, data_byte,
								e_action, hdr_left);
							res_n   = 2'd1;
						end else begin
							n_phase = PH_PAY;
						end
					end
				end
				PH_PAY: begin
					res0   = payload_item(data_byte);
					res_n  = 2'd1;
					n_left = e_left - 5'd1;
					if (e_left == 5'd1) begin
						n_phase = PH_DONE;
						res1    = status_item(ST_OK, e_company, e_version, e_flags,
							e_action, hdr_left);
						res_n   = 2'd2;
					end
				end
				default: begin
				end
			endcase
			// advance position while inside a packet
			if (e_phase == PH_WALK || e_phase == PH_HDR || e_phase == PH_PAY) begin
				n_pos = e_pos + 5'd1;
			end
		end
	end

	// hold state between accepted bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= '0;
			total_q   <= '0;
			nfs_q     <= '0;
			fl_q      <= '0;
			company_q <= '0;
			version_q <= '0;
			flags_q   <= '0;
			action_q  <= '0;
			left_q    <= '0;
		end else if (fire) begin
			phase_q   <= n_phase;
			pos_q     <= n_pos;
			total_q   <= n_total;
			nfs_q     <= n_nfs;
			fl_q      <= n_fl;
			company_q <= n_company;
			version_q <= n_version;
			flags_q   <= n_flags;
			action_q  <= n_action;
			left_q    <= n_left;
		end
	end

endmodule

`default_nettype wire

/* src/afp_fifo.sv */
// Small output word queue that takes up to two words per cycle and gives one.
// Depends on afp_pkg for the word type and depth.
`default_nettype none

module afp_fifo import afp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] push_n,
	input  wire result_t    d0,
	input  wire result_t    d1,
	input  wire logic       pop,
	output logic            not_empty,
	output logic            room2,
	output result_t         head
);

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = PTR_W + 1;

	result_t          mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_p1;

	assign wr_p1     = wr_q + PTR_W'(1);
	assign not_empty = (count_q != '0);
	assign room2     = (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign head      = mem[rd_q];

	// store words
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			mem[wr_p1] <= d1;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push_n);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

/* src/adv_mfg_field_parser.sv */
// Manufacturer field parser for advertising packets, top level.
// Output: a byte's result words are written into the output queue and offered from its head in order.
// Throughput: one byte per cycle; the last payload byte yields two words, and the
// four-word output queue drains one word per cycle, so ready falls while fewer than
// two slots are free. Reset: asynchronous, clears parse state and output queue and
// loads the register defaults.
`default_nettype none

module adv_mfg_field_parser import afp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	afp_in_if.sink           in_ch,
	afp_out_if.source        out_ch
);

	cfg_t       cfg_q;
	logic       in_fire;
	logic       out_fire;
	logic [1:0] res_n;
	result_t    res0, res1, head;
	logic       not_empty, room2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.company <= 16'd0;
			cfg_q.pairing <= 4'd0;
			cfg_q.paired  <= 4'd1;
			cfg_q.lost    <= 4'd2;
			cfg_q.enable  <= 3'd7;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COMPANY: cfg_q.company <= cfg_data;
				CFG_PAIRING: cfg_q.pairing <= cfg_data[3:0];
				CFG_PAIRED:  cfg_q.paired  <= cfg_data[3:0];
				CFG_LOST:    cfg_q.lost    <= cfg_data[3:0];
				CFG_ENABLE:  cfg_q.enable  <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// take a word only when two output slots are free
	assign in_ch.ready = room2;
	assign in_fire     = in_ch.valid && room2;
	assign out_fire    = not_empty && out_ch.ready;

	afp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (in_fire),
		.data_byte  (in_ch.data_byte),
		.first_byte (in_ch.first_byte),
		.packet_len (in_ch.packet_len),
		.cfg        (cfg_q),
		.res_n      (res_n),
		.res0       (res0),
		.res1       (res1)
	);

	afp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (in_fire ? res_n : 2'd0),
		.d0        (res0),
		.d1        (res1),
		.pop       (out_fire),
		.not_empty (not_empty),
		.room2     (room2),
		.head      (head)
	);

	// drive the output word
	assign out_ch.valid         = not_empty;
	assign out_ch.kind          = head.kind;
	assign out_ch.payload_byte  = head.payload_byte;
	assign out_ch.status        = head.status;
	assign out_ch.company       = head.company;
	assign out_ch.ver_byte      = head.ver_byte;
	assign out_ch.flag_bits     = head.flag_bits;
	assign out_ch.action        = head.action;
	assign out_ch.payload_count = head.payload_count;
	assign out_ch.last          = head.last;

	// a second word in one cycle is always the closing status
	a_pair_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_n == 2'd2 |-> res1.kind == KIND_STATUS && res0.kind == KIND_PAYLOAD)
		else $error("two words without a closing status");

	// a too-short packet reports at once
	a_short_reports: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_ch.first_byte && (in_ch.packet_len == 5'd0 ||
		in_ch.packet_len == 5'd1) |=> out_ch.valid)
		else $error("short packet gave no status word");

	// stalling the input means words are waiting
	a_stall_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> out_ch.valid)
		else $error("input stalled with empty output queue");

	// payload words carry no status
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind == KIND_PAYLOAD |->
		!out_ch.last && out_ch.status == ST_OK)
		else $error("payload word carries status");

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for adv_mfg_field_parser: random and directed advertising packets,
// bursty sender, stalling receiver, in-bench parser predictor. Needs afp_pkg and afp_if.

module tb import afp_pkg::*; ();

	localparam int PHASES      = 6;
	localparam int PHASE_BYTES = 67;
	localparam int DRAIN_LIMIT = 20000;
	localparam int SETTLE_CYC  = 4;
	localparam int NO_MATCH    = 3;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic [4:0] plen;
	} byte_word_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_MOSTLY
	} rx_mode_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = CFG_COMPANY;
	logic [15:0] cfg_data  = '0;

	afp_in_if  in_ch ();
	afp_out_if out_ch ();

	adv_mfg_field_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// register shadow, reset values
	cfg_t regs = '{company: 16'h0000, pairing: 4'h0, paired: 4'h1, lost: 4'h2, enable: 3'h7};

	// parse state of the predictor
	phase_t      ph          = PH_IDLE;
	int          pkt_len     = 0;
	int          pos         = 0;
	int          field_start = 0;
	int          fld_len     = 0;
	int          pay_left    = 0;
	logic [15:0] cap_company = '0;
	logic [7:0]  cap_version = '0;
	logic [7:0]  cap_flags   = '0;
	logic [1:0]  cap_action  = '0;

	byte_word_t pending_bytes[$];
	result_t    expected_words[$];
	int         errors = 0;

	int       burst_left = 0;
	int       gap_left   = 0;
	logic [5:0] stall_phase = '0;
	rx_mode_t stall_mode  = RX_OPEN;

	always #1 clk = ~clk;

	// queue the final status word and close the packet
	function automatic void emit_status(status_t st);
		result_t w;
		w        = '0;
		w.kind   = KIND_STATUS;
		w.status = st;
		w.last   = 1'b1;
		if (st == ST_OK) begin
			w.company       = cap_company;
			w.ver_byte      = cap_version;
			w.flag_bits     = cap_flags;
			w.action        = cap_action;
			w.payload_count = 5'(fld_len - HDR_BYTES);
		end
		expected_words.push_back(w);
		ph = PH_DONE;
	endfunction

	// advance the parse by one accepted byte
	function automatic void parse_byte(logic [7:0] b, logic first, logic [4:0] plen);
		int      off;
		int      nxt;
		int      sel;
		logic [7:0] code;
		result_t w;
		if (first) begin
			pkt_len     = (plen > MAX_PACKET) ? MAX_PACKET : plen;
			pos         = 0;
			field_start = 0;
			fld_len     = 0;
			cap_company = '0;
			cap_version = '0;
			cap_flags   = '0;
			cap_action  = '0;
			pay_left    = 0;
			if (pkt_len < 2) begin
				emit_status(ST_SHORT_PKT);
				return;
			end
			ph = PH_WALK;
		end
		if (ph == PH_IDLE || ph == PH_DONE)
			return;

		off = pos - field_start;
		case (ph)
			PH_WALK: begin
				if (off == 0) begin
					if (b == 8'h00 || field_start + b >= pkt_len)
						emit_status(ST_NO_FIELD);
					else
						fld_len = b;
				end else if (off == 1) begin
					if (b == MFG_TYPE) begin
						if (fld_len < HEADER_MIN)
							emit_status(ST_HDR_SHORT);
						else
							ph = PH_HDR;
					end else begin
						nxt = field_start + fld_len + 1;
						if (nxt + 1 >= pkt_len)
							emit_status(ST_NO_FIELD);
						else
							field_start = nxt;
					end
				end
			end
			PH_HDR: begin
				if (off == 2) begin
					cap_company = {8'h00, b};
				end else if (off == 3) begin
					cap_company[15:8] = b;
					if (cap_company != regs.company)
						emit_status(ST_COMPANY);
				end else if (off == 4) begin
					cap_version = b;
					code = b & CODE_MASK;
					// first matching code wins, even if its handler is off
					if (code[3:0] == regs.pairing)
						sel = ACT_PAIRING;
					else if (code[3:0] == regs.paired)
						sel = ACT_PAIRED;
					else if (code[3:0] == regs.lost)
						sel = ACT_LOST;
					else
						sel = NO_MATCH;
					if (sel == NO_MATCH || !regs.enable[sel])
						emit_status(ST_MODE);
					else
						cap_action = 2'(sel);
				end else if (off == 5) begin
					cap_flags = b;
					pay_left  = fld_len - HDR_BYTES;
					if (pay_left == 0)
						emit_status(ST_OK);
					else
						ph = PH_PAY;
				end
			end
			PH_PAY: begin
				w              = '0;
				w.kind         = KIND_PAYLOAD;
				w.payload_byte = b;
				expected_words.push_back(w);
				pay_left--;
				if (pay_left == 0)
					emit_status(ST_OK);
			end
			default: ;
		endcase
		if (pos < 255)
			pos++;
	endfunction

	function automatic string word_text(result_t w);
		return {$sformatf("kind=%0d byte=%02h status=%0d company=%04h ",
			w.kind, w.payload_byte, w.status, w.company),
			$sformatf("ver=%02h flags=%02h action=%0d count=%0d last=%0d",
			w.ver_byte, w.flag_bits, w.action, w.payload_count, w.last)};
	endfunction

	function automatic void push_word(logic [7:0] data, logic first, logic [4:0] plen);
		pending_bytes.push_back('{data: data, first: first, plen: plen});
	endfunction

	// build one packet, mostly well formed, and queue its bytes; returns the packet bytes queued, stray bytes not counted
	function automatic int queue_packet();
		logic [7:0] pk[$];
		int         shape;
		int         len;
		int         at;
		int         fl;
		int         room;
		int         hi;
		int         cut;
		logic [15:0] comp;
		logic [3:0]  code;
		logic [4:0]  plen;
		shape = $urandom_range(0, 99);
		len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 31) : $urandom_range(8, 31);
		if (shape < 75) begin
			// foreign fields ahead of the manufacturer field
			at = 0;
			repeat ($urandom_range(0, 2)) begin
				fl = $urandom_range(1, 4);
				if (at + fl + 8 < len) begin
					pk.push_back(8'(fl));
					pk.push_back(8'($urandom_range(0, 254)));
					repeat (fl - 1) pk.push_back(8'($urandom));
					at += fl + 1;
				end
			end
			room = len - 1 - at;
			if (shape < 5) begin
				fl = room + 1;
			end else if (shape < 10) begin
				fl = $urandom_range(1, 4);
			end else if (room >= HEADER_MIN) begin
				hi = ($urandom_range(0, 3) == 0 || room < 10) ? room : 10;
				fl = $urandom_range(HEADER_MIN, hi);
			end else begin
				fl = $urandom_range(1, 5);
			end
			comp = ($urandom_range(0, 9) == 0) ? 16'($urandom) : regs.company;
			case ($urandom_range(0, 3))
				0: code = regs.pairing;
				1: code = regs.paired;
				2: code = regs.lost;
				default: code = 4'($urandom);
			endcase
			pk.push_back(8'(fl));
			pk.push_back(MFG_TYPE);
			pk.push_back(comp[7:0]);
			pk.push_back(comp[15:8]);
			pk.push_back({4'($urandom), code});
			pk.push_back(8'($urandom));
			repeat (fl - int'(HDR_BYTES)) pk.push_back(8'($urandom));
		end else begin
			// noise with likely zero-length or manufacturer starts
			repeat (len) pk.push_back(8'($urandom));
			if ($urandom_range(0, 3) == 0)
				pk[0] = 8'h00;
			if (len > 1 && $urandom_range(0, 2) == 0)
				pk[1] = MFG_TYPE;
		end
		while (pk.size() > len)
			void'(pk.pop_back());
		while (pk.size() < len)
			pk.push_back(8'($urandom));

		// sometimes cut the packet short
		cut = ($urandom_range(0, 14) == 0) ? $urandom_range(1, len) : len;
		for (int i = 0; i < cut; i++) begin
			plen = 5'(len);
			if (i > 0 && $urandom_range(0, 19) == 0)
				plen = 5'($urandom_range(1, 31));
			push_word(pk[i], i == 0, plen);
		end
		// stray bytes after the packet
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) push_word(8'($urandom), 1'b0, 5'($urandom_range(1, 31)));
		return cut;
	endfunction

	// wait for the pipe to empty, then let the bench idle
	task automatic settle();
		int waited;
		waited = 0;
		do begin
			@(negedge clk);
			waited++;
		end while ((pending_bytes.size() != 0 || in_ch.valid || expected_words.size() != 0)
			&& waited < DRAIN_LIMIT);
		if (expected_words.size() != 0) begin
			$display("%0t: %0d expected words never arrived, next %s", $time,
				expected_words.size(), word_text(expected_words[0]));
			errors++;
			expected_words.delete();
		end
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_COMPANY: regs.company = val;
			CFG_PAIRING: regs.pairing = val[3:0];
			CFG_PAIRED:  regs.paired  = val[3:0];
			CFG_LOST:    regs.lost    = val[3:0];
			CFG_ENABLE:  regs.enable  = val[2:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(logic [15:0] comp, logic [3:0] pairing, logic [3:0] paired,
			logic [3:0] lost, logic [2:0] enable);
		write_reg(CFG_COMPANY, comp);
		write_reg(CFG_PAIRING, 16'(pairing));
		write_reg(CFG_PAIRED, 16'(paired));
		write_reg(CFG_LOST, 16'(lost));
		write_reg(CFG_ENABLE, 16'(enable));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// byte sender: bursts of random length, random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid      <= 1'b0;
			in_ch.data_byte  <= '0;
			in_ch.first_byte <= 1'b0;
			in_ch.packet_len <= '0;
			burst_left       <= 0;
			gap_left         <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (gap_left != 0) begin
				gap_left    <= gap_left - 1;
				in_ch.valid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				in_ch.valid      <= 1'b1;
				in_ch.data_byte  <= pending_bytes[0].data;
				in_ch.first_byte <= pending_bytes[0].first;
				in_ch.packet_len <= pending_bytes[0].plen;
				pending_bytes.delete(0);
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches each time the six-bit phase counter wraps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_phase  <= '0;
			stall_mode   <= RX_OPEN;
		end else begin
			stall_phase <= stall_phase + 1'b1;
			if (stall_phase == 6'd63)
				stall_mode <= rx_mode_t'($urandom_range(0, 3));
			case (stall_mode)
				RX_OPEN:   out_ch.ready <= 1'b1;
				RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ch.ready <= (stall_phase[1:0] == 2'd0);
				default:   out_ch.ready <= (stall_phase[2:0] != 3'd0);
			endcase
		end
	end

	// check each output word, then predict from the accepted byte
	always @(posedge clk) begin : check_words
		result_t got;
		result_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{kind: out_ch.kind, payload_byte: out_ch.payload_byte,
					status: out_ch.status, company: out_ch.company,
					ver_byte: out_ch.ver_byte, flag_bits: out_ch.flag_bits,
					action: out_ch.action, payload_count: out_ch.payload_count,
					last: out_ch.last};
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected word: expected none, actual %s", $time,
						word_text(got));
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: word mismatch: expected %s", $time, word_text(want));
						$display("%0t: word mismatch: actual   %s", $time, word_text(got));
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				parse_byte(in_ch.data_byte, in_ch.first_byte, in_ch.packet_len);
		end
	end

	initial begin
		int sent;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings
		push_word(8'h5A, 1'b0, 5'd9);           // byte outside any packet
		push_word(8'h00, 1'b1, 5'd1);           // length below two
		push_word(8'h00, 1'b1, 5'd2);           // zero-length field
		push_word(8'hFF, 1'b0, 5'd2);
		push_word(8'h03, 1'b1, 5'd4);           // manufacturer field too short for header
		push_word(8'hFF, 1'b0, 5'd4);
		push_word(8'h05, 1'b1, 5'd6);           // pairing, empty payload, restarts the above
		push_word(MFG_TYPE, 1'b0, 5'd6);
		push_word(8'h00, 1'b0, 5'd6);
		push_word(8'h00, 1'b0, 5'd6);
		push_word(8'hF0, 1'b0, 5'd6);
		push_word(8'hA5, 1'b0, 5'd6);
		push_word(8'h01, 1'b1, 5'd10);          // foreign field, then paired with one byte
		push_word(8'h09, 1'b0, 5'd10);
		push_word(8'h06, 1'b0, 5'd31);          // length change after first byte
		push_word(MFG_TYPE, 1'b0, 5'd10);
		push_word(8'h00, 1'b0, 5'd10);
		push_word(8'h00, 1'b0, 5'd10);
		push_word(8'h01, 1'b0, 5'd10);
		push_word(8'h3C, 1'b0, 5'd10);
		push_word(8'hFF, 1'b0, 5'd10);
		push_word(8'h00, 1'b0, 5'd10);          // ignored after the decision

		// random packets under several register settings
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: load_settings(16'hFFFF, 4'hF, 4'h0, 4'hF, 3'd7);
				1: load_settings(16'h0000, 4'h0, 4'h0, 4'h0, 3'd0);
				2: load_settings(16'($urandom), 4'h3, 4'h3, 4'h9, 3'b110);
				default: load_settings(16'($urandom), 4'($urandom), 4'($urandom),
					4'($urandom), 3'($urandom));
			endcase
			sent = 0;
			while (sent < PHASE_BYTES)
				sent += queue_packet();
		end
		settle();

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// hang guard
	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

endmodule
